// File: sv/akf_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and saturation helpers for the angle Kalman filter.
// No dependencies; imported by every other file of the block.
package akf_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [31:0] ANGLE_NOISE_RST   = 32'd16777;
  localparam logic [31:0] BIAS_NOISE_RST    = 32'd50332;
  localparam logic [31:0] MEASURE_NOISE_RST = 32'd503316;

  // product formats: sets bit count of the serial operand and the final shift
  typedef enum logic [1:0] {
    MK_DT,     // x * dt, Q0.20 scaling
    MK_NOISE,  // bias noise * dt, Q8.24 to Q16.32
    MK_Y,      // gain * innovation
    MK_COV     // gain * covariance
  } mul_kind_t;

  typedef struct packed {
    logic      start;
    mul_kind_t kind;
    logic      neg;
  } mul_req_t;

  function automatic logic [5:0] mul_bits(input mul_kind_t k);
    case (k)
      MK_DT:    return 6'd20;
      MK_NOISE: return 6'd20;
      MK_Y:     return 6'd33;
      MK_COV:   return 6'd48;
      default:  return 6'd48;
    endcase
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] x);
    if (x[63:31] == '0 || x[63:31] == '1) return x[31:0];
    else if (x[63]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

  function automatic logic [47:0] sat48(input logic [63:0] x);
    if (x[63:47] == '0 || x[63:47] == '1) return x[47:0];
    else if (x[63]) return 48'h8000_0000_0000;
    else return 48'h7FFF_FFFF_FFFF;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] sx48(input logic [47:0] x);
    return {{16{x[47]}}, x};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] sx33(input logic [32:0] x);
    return {{31{x[32]}}, x};
  endfunction

endpackage

// File: sv/akf_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one bit of the B operand per cycle, then
// floor rounding at the product format and saturation to 62 bits. Uses akf_pkg.
module akf_mul import akf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  input  logic [63:0] op_a,    // magnitude
  input  logic [47:0] op_b,    // magnitude
  output logic        done,
  output logic [63:0] result   // signed, 62-bit range
);

  logic        busy;
  logic        fin;
  logic [5:0]  cnt;
  logic [63:0] a;
  logic [47:0] b;
  logic        neg;
  mul_kind_t   kind;
  logic [127:0] acc;

  logic [64:0]  sum;
  logic [127:0] acc_next;
  logic [127:0] q;
  logic         sticky;
  logic         big;
  logic [63:0]  res_next;

  // one shift-add step
  always_comb begin
    sum      = {1'b0, acc[127:64]} + (b[0] ? {1'b0, a} : 65'd0);
    acc_next = {sum, acc[63:1]};
  end

  // product sits at offset 64-n; drop that plus the format shift
  always_comb begin
    case (kind)
      MK_DT: begin
        q      = acc >> 64;
        sticky = |acc[63:0];
      end
      MK_NOISE: begin
        q      = acc >> 56;
        sticky = |acc[55:0];
      end
      MK_Y: begin
        q      = acc >> 63;
        sticky = |acc[62:0];
      end
      default: begin
        q      = acc >> 48;
        sticky = |acc[47:0];
      end
    endcase
    big = |q[127:61];
    if (!neg) begin
      res_next = big ? 64'h1FFF_FFFF_FFFF_FFFF : {3'b000, q[60:0]};
    end else if (big || (&q[60:0] && sticky)) begin
      res_next = 64'hE000_0000_0000_0000;
    end else begin
      res_next = 64'd0 - ({3'b000, q[60:0]} + {63'd0, sticky});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy && !fin) begin
        a    <= op_a;
        b    <= op_b;
        neg  <= req.neg;
        kind <= req.kind;
        acc  <= '0;
        cnt  <= mul_bits(req.kind);
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        b   <= b >> 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        result <= res_next;
        done   <= 1'b1;
        fin    <= 1'b0;
      end
    end
  end

endmodule

// File: sv/akf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: trunc(num * 2^32 / den),
// saturated to 48 bits signed, zero for a zero divisor. Uses akf_pkg.
module akf_div import akf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,     // signed, 48-bit range
  input  logic [63:0] den,     // signed, 49-bit range
  output logic        done,
  output logic [63:0] result   // signed, 48-bit range
);

  logic        busy;
  logic        fin;
  logic [6:0]  cnt;
  logic [79:0] dvd;
  logic [49:0] ud;
  logic [49:0] rem;
  logic        neg;

  logic [50:0] rem2;
  logic        ge;
  logic        big;
  logic [63:0] res_next;
  logic [63:0] num_mag;
  logic [63:0] den_mag;

  assign num_mag = mag64(num);
  assign den_mag = mag64(den);

  // one trial subtract
  always_comb begin
    rem2 = {rem, dvd[79]};
    ge   = rem2 >= {1'b0, ud};
  end

  always_comb begin
    big = |dvd[79:47];
    if (ud == '0) begin
      res_next = '0;
    end else if (!neg) begin
      res_next = big ? 64'h0000_7FFF_FFFF_FFFF : {17'd0, dvd[46:0]};
    end else begin
      res_next = big ? 64'hFFFF_8000_0000_0000 : 64'd0 - {17'd0, dvd[46:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy && !fin) begin
        dvd  <= {num_mag[47:0], 32'd0};
        ud   <= den_mag[49:0];
        rem  <= '0;
        neg  <= num[63] ^ den[63];
        cnt  <= 7'd80;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? rem2[49:0] - ud : rem2[49:0];
        dvd <= {dvd[78:0], ge};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        result <= res_next;
        done   <= 1'b1;
        fin    <= 1'b0;
      end
    end
  end

endmodule

// File: sv/angle_kalman_filter.sv
`timescale 1ns / 1ps
// Top level of the two-state angle / gyro-bias Kalman filter: step sequencer,
// filter state and stream ports. Uses akf_pkg, akf_mul and akf_div.
//
// Usage:
//   s_* channel: one beat per sample (measured angle, gyro rate, time step).
//   m_* channel: one beat per sample, the new angle estimate, Q16.16.
//   cfg_*: noise registers, written while the filter is idle, no read-back.
// One sample is processed at a time. s_tready is high only while the
// sequencer is idle. A sample runs twelve steps on two shared units: a
// bit-serial multiplier (n = 20, 33 or 48 bits of the serial operand) and
// a restoring divider.
// The result sits in an output register: the next sample is accepted while
// it waits. If the receiver stalls and the register is still full at the
// end of the next sample, the sequencer holds until it is taken.
// Reset clears angle, bias and covariance to zero, loads the default noise
// values and empties the output register.
module angle_kalman_filter import akf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // [31:0] measured_angle, [63:32] measured_rate,
                                 // [83:64] time_step, [87:84] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] angle_estimate
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

  localparam logic [3:0] STEP_LAST = 4'd11;

  state_t      state;
  logic [3:0]  step;
  logic        pend;

  logic [31:0] angle_noise;
  logic [31:0] bias_noise;
  logic [31:0] measure_noise;

  logic [31:0] angle_state;
  logic [31:0] bias_state;
  logic [47:0] cov_00;
  logic [47:0] cov_01;
  logic [47:0] cov_10;
  logic [47:0] cov_11;

  logic [31:0] meas;
  logic [32:0] rate;
  logic [19:0] dt;
  logic [31:0] ap;
  logic [63:0] t;
  logic [48:0] s;
  logic [47:0] p00;
  logic [47:0] p01;
  logic [47:0] p10;
  logic [47:0] p11;
  logic [47:0] k0;
  logic [47:0] k1;
  logic [32:0] y;

  mul_req_t    mreq;
  logic [63:0] mul_a;
  logic [47:0] mul_b;
  logic        mul_done;
  logic [63:0] r;
  logic        is_div;
  logic        div_start;
  logic [63:0] div_num;
  logic        div_done;
  logic [63:0] div_res;
  logic [63:0] sx_a;
  logic [63:0] sx_b;
  logic        op_done;

  assign s_tready = (state == ST_IDLE);

  // operand selection for each step, magnitudes and start strobes
  always_comb begin
    logic [63:0] mb;
    sx_a      = '0;
    sx_b      = '0;
    mreq.kind = MK_DT;
    is_div    = 1'b0;
    div_num   = sx48(p00);
    case (step)
      4'd0: begin
        sx_a = sx33(rate);
        sx_b = {44'd0, dt};
      end
      4'd1: begin
        sx_a = sx48(cov_11);
        sx_b = {44'd0, dt};
      end
      4'd2: begin
        sx_a = t;
        sx_b = {44'd0, dt};
      end
      4'd3: begin
        sx_a      = {32'd0, bias_noise};
        sx_b      = {44'd0, dt};
        mreq.kind = MK_NOISE;
      end
      4'd4: is_div = 1'b1;
      4'd5: begin
        is_div  = 1'b1;
        div_num = sx48(p10);
      end
      4'd6: begin
        sx_a      = sx48(k0);
        sx_b      = sx33(y);
        mreq.kind = MK_Y;
      end
      4'd7: begin
        sx_a      = sx48(k1);
        sx_b      = sx33(y);
        mreq.kind = MK_Y;
      end
      4'd8: begin
        sx_a      = sx48(k0);
        sx_b      = sx48(p00);
        mreq.kind = MK_COV;
      end
      4'd9: begin
        sx_a      = sx48(k0);
        sx_b      = sx48(p01);
        mreq.kind = MK_COV;
      end
      4'd10: begin
        sx_a      = sx48(k1);
        sx_b      = sx48(p00);
        mreq.kind = MK_COV;
      end
      4'd11: begin
        sx_a      = sx48(k1);
        sx_b      = sx48(p01);
        mreq.kind = MK_COV;
      end
      default: begin
        sx_a = '0;
        sx_b = '0;
      end
    endcase
    mb         = mag64(sx_b);
    mul_a      = mag64(sx_a);
    mul_b      = mb[47:0];
    mreq.neg   = sx_a[63] ^ sx_b[63];
    mreq.start = (state == ST_RUN) && !pend && !is_div;
    div_start  = (state == ST_RUN) && !pend && is_div;
    op_done    = mul_done || div_done;
  end

  akf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (r)
  );

  akf_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    ({{15{s[48]}}, s}),
    .done   (div_done),
    .result (div_res)
  );

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      pend          <= 1'b0;
      m_tvalid      <= 1'b0;
      angle_noise   <= ANGLE_NOISE_RST;
      bias_noise    <= BIAS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
      angle_state   <= '0;
      bias_state    <= '0;
      cov_00        <= '0;
      cov_01        <= '0;
      cov_10        <= '0;
      cov_11        <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ANGLE_NOISE:   angle_noise   <= cfg_data;
          REG_BIAS_NOISE:    bias_noise    <= cfg_data;
          REG_MEASURE_NOISE: measure_noise <= cfg_data;
          default: ;
        endcase
      end

      // a taken beat empties the output register unless a new one is loaded
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            meas  <= s_tdata[31:0];
            rate  <= {s_tdata[63], s_tdata[63:32]} - {bias_state[31], bias_state};
            dt    <= s_tdata[83:64];
            step  <= '0;
            pend  <= 1'b0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (op_done) begin
            pend <= 1'b0;
            step <= step + 4'd1;
            case (step)
              // predict
              4'd0: ap <= sat32(sx32(angle_state) + r);
              4'd1: begin
                t   <= r - sx48(cov_01) - sx48(cov_10) + {24'd0, angle_noise, 8'd0};
                p01 <= sat48(sx48(cov_01) - r);
                p10 <= sat48(sx48(cov_10) - r);
              end
              4'd2: p00 <= sat48(sx48(cov_00) + r);
              4'd3: begin
                p11 <= sat48(sx48(cov_11) + r);
                s   <= {p00[47], p00} + {9'd0, measure_noise, 8'd0};
              end
              // gains
              4'd4: k0 <= div_res[47:0];
              4'd5: begin
                k1 <= div_res[47:0];
                y  <= {meas[31], meas} - {ap[31], ap};
              end
              // update
              4'd6:  angle_state <= sat32(sx32(ap) + r);
              4'd7:  bias_state  <= sat32(sx32(bias_state) + r);
              4'd8:  cov_00      <= sat48(sx48(p00) - r);
              4'd9:  cov_01      <= sat48(sx48(p01) - r);
              4'd10: cov_10      <= sat48(sx48(p10) - r);
              4'd11: cov_11      <= sat48(sx48(p11) - r);
              default: ;
            endcase
            if (step == STEP_LAST) begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= angle_state;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
